/* hw/rtl/swm_pkg.sv */
// Shared types and constants for the sliding-window median filter.
// No dependencies.
`default_nettype none

package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int SIZE_W         = 5;
    localparam int WINDOW_MAX_DEF = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(5);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [SIZE_W-1:0]        size_t;

endpackage

`default_nettype wire

/* hw/rtl/sliding_window_median_filter.sv */
// Sliding-window median filter, top level. Uses swm_pkg and swm_ram.
// A request goes through ST_OLD (ring read and write), a single read/write pass
//   over the sorted-window RAM (ST_SCAN, ST_FLUSH) and ST_DONE before m_valid;
//   when window_size is 0 or above WINDOW_MAX the sample passes through.
// s_ready is high only in ST_IDLE: no new request is taken until ST_DONE loads m_median.
// Reset: synchronous active-low aresetn; window_size=5, window all zeros, pos 0.
`default_nettype none

module sliding_window_median_filter
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    // config: window_size, clears the window on write
    input  wire logic  cfg_wen,
    input  wire size_t cfg_wdata,
    // sample request
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire data_t s_sample,
    // median result
    output logic       m_valid,
    input  wire logic  m_ready,
    output data_t      m_median
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    // Two memories:
    //   ring RAM   - samples in arrival order, slot pos_reg is the oldest
    //   sorted RAM - the same multiset in ascending signed order
    // Per item: read the oldest sample from the ring, overwrite it, then stream
    // the sorted RAM once, dropping one copy of the old value and merging the
    // new one in. A one-entry hold register absorbs the one-slot skew between
    // read and write positions. Writes always land at or below the index just
    // read, so the pass never reads an entry it has already rewritten.
    // The median is caught as the pass writes index (n-1)/2.
    // Entries never written since reset/config read as zero via valid bits.

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    size_t                 size_reg, size_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [WINDOW_MAX-1:0] ring_vld_reg, ring_vld_next;
    logic [WINDOW_MAX-1:0] srt_vld_reg, srt_vld_next;
    logic                  m_valid_reg, m_valid_next;

    // pass bookkeeping
    logic                  del_reg, del_next;     // old value already dropped
    logic                  ins_reg, ins_next;     // new value already merged
    logic                  hold_vld_reg, hold_vld_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;     // index of data now arriving
    logic [CNT_W-1:0]      wp_reg, wp_next;       // next sorted write index

    // payload
    data_t                 sample_reg, sample_next;
    data_t                 old_reg, old_next;
    data_t                 hold_reg, hold_next;
    data_t                 med_reg, med_next;
    data_t                 m_median_reg, m_median_next;

    // RAM ports
    logic                  ring_we;
    logic [IDX_W-1:0]      ring_raddr;
    logic [DATA_W-1:0]     ring_rdata;
    logic                  srt_we;
    logic [IDX_W-1:0]      srt_waddr;
    data_t                 srt_wdata;
    logic [IDX_W-1:0]      srt_raddr;
    logic [DATA_W-1:0]     srt_rdata;

    logic [CNT_W-1:0]      n_win;
    logic [CNT_W-1:0]      med_idx;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  bypass;
    data_t                 x_val;
    data_t                 old_val;

    swm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    swm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_sort_ram (
        .aclk  (aclk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    assign n_win   = CNT_W'(size_reg);
    assign med_idx = (n_win - CNT_W'(1)) >> 1;
    assign cnt_inc = cnt_reg + CNT_W'(1);
    // size 0 or oversize: pass the sample through, window untouched
    assign bypass  = (size_reg == '0) || (32'(size_reg) > 32'(WINDOW_MAX));

    assign x_val   = srt_vld_reg[cnt_reg[IDX_W-1:0]] ? data_t'(srt_rdata) : '0;
    assign old_val = ring_vld_reg[pos_reg] ? data_t'(ring_rdata) : '0;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;

    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        pos_next      = pos_reg;
        ring_vld_next = ring_vld_reg;
        srt_vld_next  = srt_vld_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        del_next      = del_reg;
        ins_next      = ins_reg;
        hold_vld_next = hold_vld_reg;
        cnt_next      = cnt_reg;
        wp_next       = wp_reg;
        sample_next   = sample_reg;
        old_next      = old_reg;
        hold_next     = hold_reg;
        med_next      = med_reg;
        m_median_next = m_median_reg;

        ring_we    = 1'b0;
        ring_raddr = pos_reg;
        srt_we     = 1'b0;
        srt_waddr  = wp_reg[IDX_W-1:0];
        srt_wdata  = x_val;
        srt_raddr  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample;
                    if (bypass) begin
                        med_next   = s_sample;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_OLD;   // ring read of oldest slot issued
                    end
                end
            end

            ST_OLD: begin
                old_next               = old_val;
                ring_we                = 1'b1;
                ring_vld_next[pos_reg] = 1'b1;
                if (CNT_W'(pos_reg) + CNT_W'(1) == n_win) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + IDX_W'(1);
                end
                srt_raddr     = '0;
                cnt_next      = '0;
                wp_next       = '0;
                del_next      = 1'b0;
                ins_next      = 1'b0;
                hold_vld_next = 1'b0;
                state_next    = ST_SCAN;
            end

            ST_SCAN: begin
                srt_raddr = cnt_inc[IDX_W-1:0];
                cnt_next  = cnt_inc;
                priority if (!del_reg && x_val == old_reg) begin
                    // drop this copy of the outgoing sample
                    del_next = 1'b1;
                    if (hold_vld_reg) begin
                        srt_we        = 1'b1;
                        srt_wdata     = hold_reg;
                        wp_next       = wp_reg + CNT_W'(1);
                        hold_vld_next = 1'b0;
                    end
                end else if (!ins_reg && sample_reg < x_val) begin
                    // new sample goes here, current element slides up
                    ins_next      = 1'b1;
                    srt_we        = 1'b1;
                    srt_wdata     = sample_reg;
                    wp_next       = wp_reg + CNT_W'(1);
                    hold_next     = x_val;
                    hold_vld_next = 1'b1;
                end else begin
                    srt_we    = 1'b1;
                    srt_wdata = hold_vld_reg ? hold_reg : x_val;
                    wp_next   = wp_reg + CNT_W'(1);
                    hold_next = x_val;
                end
                if (cnt_inc == n_win) begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                // last slot: the held element, or the new sample if it is largest
                if (!ins_reg || hold_vld_reg) begin
                    srt_we    = 1'b1;
                    srt_wdata = hold_vld_reg ? hold_reg : sample_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_median_next = med_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (srt_we) begin
            srt_vld_next[srt_waddr] = 1'b1;
            if (wp_reg == med_idx) begin
                med_next = srt_wdata;
            end
        end

        // window size write clears both stores and the position
        if (cfg_wen) begin
            size_next     = cfg_wdata;
            pos_next      = '0;
            ring_vld_next = '0;
            srt_vld_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= SIZE_RESET;
            pos_reg      <= '0;
            ring_vld_reg <= '0;
            srt_vld_reg  <= '0;
            m_valid_reg  <= 1'b0;
            del_reg      <= 1'b0;
            ins_reg      <= 1'b0;
            hold_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            wp_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            pos_reg      <= pos_next;
            ring_vld_reg <= ring_vld_next;
            srt_vld_reg  <= srt_vld_next;
            m_valid_reg  <= m_valid_next;
            del_reg      <= del_next;
            ins_reg      <= ins_next;
            hold_vld_reg <= hold_vld_next;
            cnt_reg      <= cnt_next;
            wp_reg       <= wp_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        old_reg      <= old_next;
        hold_reg     <= hold_next;
        med_reg      <= med_next;
        m_median_reg <= m_median_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/swm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
